FILE: hw/rtl/u2d_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`default_nettype none

package u2d_pkg;

    // Default number of entries in the queue between front and back.
    localparam int QueueDepth = 2;

    // Byte classes, decided from the byte alone.
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,   // 0xxxxxxx
        CLS_LEAD2 = 3'd1,   // 110xxxxx
        CLS_LEAD3 = 3'd2,   // 1110xxxx
        CLS_CONT  = 3'd3,   // 10xxxxxx
        CLS_BAD   = 3'd4    // 1111xxxx
    } u2d_class_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_ERROR   = 2'd1,
        STATUS_PARTIAL = 2'd2
    } u2d_status_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        u2d_class_t  cls;
        logic [7:0]  data;
        logic        last;
    } u2d_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/u2d_front.sv
// Front stage: accepts input bytes, classifies them and pushes them to the queue.
`default_nettype none

module u2d_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_in_byte,
    input  wire logic               s_end_of_buffer,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output u2d_pkg::u2d_entry_t     push_entry
);

    logic                 valid_reg;
    logic                 valid_next;
    u2d_pkg::u2d_entry_t  entry_reg;
    u2d_pkg::u2d_entry_t  entry_next;
    u2d_pkg::u2d_class_t  cls;

    always_comb begin
        if (s_in_byte[7] == 1'b0) begin
            cls = u2d_pkg::CLS_ASCII;
        end else if (s_in_byte[6] == 1'b0) begin
            cls = u2d_pkg::CLS_CONT;
        end else if (s_in_byte[5] == 1'b0) begin
            cls = u2d_pkg::CLS_LEAD2;
        end else if (s_in_byte[4] == 1'b0) begin
            cls = u2d_pkg::CLS_LEAD3;
        end else begin
            cls = u2d_pkg::CLS_BAD;
        end
    end

    // Take a new item whenever the register is empty or the held one leaves in the same cycle.
    assign s_ready = !valid_reg || push_ready;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (s_valid && s_ready) begin
            valid_next      = 1'b1;
            entry_next.cls  = cls;
            entry_next.data = s_in_byte;
            entry_next.last = s_end_of_buffer;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/u2d_queue.sv
// Short queue of classified items between the front and back stages.
`default_nettype none

module u2d_queue #(
    parameter int DEPTH = u2d_pkg::QueueDepth
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire u2d_pkg::u2d_entry_t  push_entry,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output u2d_pkg::u2d_entry_t       pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2d_pkg::u2d_entry_t  entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_entry  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    count_tracks_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    full_blocks_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) |-> !push)
        else $error("push into full queue");

endmodule

`default_nettype wire

FILE: hw/rtl/u2d_back.sv
// Back stage: assembles sequences from classified items and holds the result register.
`default_nettype none

module u2d_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire u2d_pkg::u2d_entry_t  pop_entry,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [15:0]               m_code_point,
    output logic [1:0]                m_bytes_used,
    output logic [1:0]                m_status
);

    localparam logic [1:0] SeqNone  = 2'd0;
    localparam logic [1:0] SeqTwo   = 2'd2;
    localparam logic [1:0] SeqThree = 2'd3;

    logic [1:0]   seq_length_reg;
    logic [1:0]   seq_length_next;
    logic [1:0]   bytes_seen_reg;
    logic [1:0]   bytes_seen_next;
    logic [9:0]   partial_reg;
    logic [9:0]   partial_next;
    logic         m_valid_reg;
    logic         m_valid_next;
    logic [15:0]  cp_reg;
    logic [15:0]  cp_next;
    logic [1:0]   used_reg;
    logic [1:0]   used_next;
    logic [1:0]   status_reg;
    logic [1:0]   status_next;

    logic         pop;
    logic         emit;
    logic [15:0]  res_cp;
    logic [1:0]   res_used;
    logic [1:0]   res_status;
    logic [15:0]  acc;
    logic [1:0]   seen;

    assign pop_ready = !m_valid_reg || m_ready;
    assign pop       = pop_valid && pop_ready;

    assign acc  = {partial_reg, pop_entry.data[5:0]};
    assign seen = bytes_seen_reg + 2'd1;

    // Sequence state and result for the item at the head of the queue.
    always_comb begin
        seq_length_next = seq_length_reg;
        bytes_seen_next = bytes_seen_reg;
        partial_next    = partial_reg;
        emit            = 1'b0;
        res_cp          = '0;
        res_used        = '0;
        res_status      = u2d_pkg::STATUS_OK;
        if (!(seq_length_reg inside {SeqTwo, SeqThree})) begin
            seq_length_next = SeqNone;
            bytes_seen_next = '0;
            partial_next    = '0;
            case (pop_entry.cls)
                u2d_pkg::CLS_ASCII: begin
                    emit     = 1'b1;
                    res_cp   = {8'd0, pop_entry.data};
                    res_used = 2'd1;
                end
                u2d_pkg::CLS_LEAD2, u2d_pkg::CLS_LEAD3: begin
                    if (pop_entry.last) begin
                        emit       = 1'b1;
                        res_status = u2d_pkg::STATUS_PARTIAL;
                    end else if (pop_entry.cls == u2d_pkg::CLS_LEAD2) begin
                        seq_length_next = SeqTwo;
                        bytes_seen_next = 2'd1;
                        partial_next    = {5'd0, pop_entry.data[4:0]};
                    end else begin
                        seq_length_next = SeqThree;
                        bytes_seen_next = 2'd1;
                        partial_next    = {6'd0, pop_entry.data[3:0]};
                    end
                end
                default: begin
                    emit       = 1'b1;
                    res_status = u2d_pkg::STATUS_ERROR;
                end
            endcase
        end else if (pop_entry.cls != u2d_pkg::CLS_CONT) begin
            // Drop the pending sequence along with the bad byte.
            seq_length_next = SeqNone;
            bytes_seen_next = '0;
            partial_next    = '0;
            emit            = 1'b1;
            res_status      = u2d_pkg::STATUS_ERROR;
        end else if (seen >= seq_length_reg) begin
            seq_length_next = SeqNone;
            bytes_seen_next = '0;
            partial_next    = '0;
            emit            = 1'b1;
            res_cp          = acc;
            res_used        = seq_length_reg;
        end else if (pop_entry.last) begin
            seq_length_next = SeqNone;
            bytes_seen_next = '0;
            partial_next    = '0;
            emit            = 1'b1;
            res_status      = u2d_pkg::STATUS_PARTIAL;
        end else begin
            bytes_seen_next = seen;
            partial_next    = acc[9:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        cp_next      = cp_reg;
        used_next    = used_reg;
        status_next  = status_reg;
        if (pop && emit) begin
            m_valid_next = 1'b1;
            cp_next      = res_cp;
            used_next    = res_used;
            status_next  = res_status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_length_reg <= SeqNone;
            bytes_seen_reg <= '0;
            partial_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                seq_length_reg <= seq_length_next;
                bytes_seen_reg <= bytes_seen_next;
                partial_reg    <= partial_next;
            end
            m_valid_reg <= m_valid_next;
        end
        cp_reg     <= cp_next;
        used_reg   <= used_next;
        status_reg <= status_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;
    assign m_bytes_used = used_reg;
    assign m_status     = status_reg;

    no_length_one: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_length_reg != 2'd1)
        else $error("pending length of one");

    idle_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_length_reg == SeqNone) |-> (bytes_seen_reg == 2'd0 && partial_reg == 10'd0))
        else $error("idle decoder holds leftover state");

    pending_count_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_length_reg != SeqNone) |->
            (bytes_seen_reg != 2'd0 && bytes_seen_reg < seq_length_reg))
        else $error("pending byte count out of range");

    bad_result_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != u2d_pkg::STATUS_OK) |->
            (cp_reg == 16'd0 && used_reg == 2'd0))
        else $error("error or partial result carries data");

    good_result_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == u2d_pkg::STATUS_OK) |-> (used_reg != 2'd0))
        else $error("character result without byte count");

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder: front, queue and back stages.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_in_byte[7:0], s_end_of_buffer
//  m_      | out       | m_valid / m_ready  | m_code_point[15:0], m_bytes_used[1:0],
//          |           |                    | m_status[1:0]
//
// Unless stalled, one byte is accepted per clock; the back stage pops one byte per cycle.
// With an empty queue, a byte that yields a result is held in the front register, a queue
// entry and the output register, in that order, before m_valid rises.
// aresetn is synchronous and active low; it empties the queue and drops any pending sequence.
// When m_ready stays low the output register, queue and front register fill in turn,
// then s_ready falls; all resume at full rate as neighbors move, a full queue after a pop.
`default_nettype none

module utf8_to_ucs2_decoder #(
    parameter int QUEUE_DEPTH = u2d_pkg::QueueDepth
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_in_byte,
    input  wire logic         s_end_of_buffer,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_code_point,
    output logic [1:0]        m_bytes_used,
    output logic [1:0]        m_status
);

    logic                 push_valid;
    logic                 push_ready;
    u2d_pkg::u2d_entry_t  push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    u2d_pkg::u2d_entry_t  pop_entry;

    u2d_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_entry      (push_entry)
    );

    u2d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    u2d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_bytes_used (m_bytes_used),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

FILE: bench/utf8_to_ucs2_decoder_tb.sv
// Self-checking bench for the UTF-8 to UCS-2 decoder, with directed rows and random byte streams.
`timescale 1ns / 100ps

module utf8_to_ucs2_decoder_tb;

    typedef struct packed {
        logic [15:0]          code_point;
        logic [1:0]           bytes_used;
        u2d_pkg::u2d_status_t status;
    } char_result_t;

    typedef struct packed {
        logic [7:0]   in_byte;
        logic         eob;
        logic         typed;
        char_result_t res;
    } stim_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam int NUM_RANDOM   = 800;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    // Typed rows carry a result that reads straight off the decoding rules.
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, '{16'h0000, 2'd1, u2d_pkg::STATUS_OK}},
        '{8'h7f, 1'b0, 1'b1, '{16'h007f, 2'd1, u2d_pkg::STATUS_OK}},
        '{8'h80, 1'b1, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_ERROR}},
        '{8'hff, 1'b0, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_ERROR}},
        '{8'hf0, 1'b0, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_ERROR}},
        '{8'hc2, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'ha9, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hc0, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'h80, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'he0, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'h80, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'h80, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hef, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hbf, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hbf, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'he2, 1'b1, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_PARTIAL}},
        '{8'he2, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'h82, 1'b1, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_PARTIAL}},
        '{8'hc3, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'h41, 1'b0, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_ERROR}},
        '{8'he4, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hb8, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'had, 1'b1, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'he1, 1'b0, 1'b0, '{16'h0000, 2'd0, u2d_pkg::STATUS_OK}},
        '{8'hc0, 1'b1, 1'b1, '{16'h0000, 2'd0, u2d_pkg::STATUS_ERROR}}
    };

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte       = 8'h00;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [15:0] m_code_point;
    logic [1:0]  m_bytes_used;
    logic [1:0]  m_status;

    // Decoder state mirrored by the bench.
    logic [1:0] seq_len  = 2'd0;
    logic [1:0] seq_seen = 2'd0;
    logic [9:0] seq_bits = 10'd0;

    char_result_t decoded_q [$];
    int  mismatch_count = 0;
    bit  no_idle        = 1'b0;
    bit  hold_req       = 1'b0;
    bit  hold_active    = 1'b0;

    utf8_to_ucs2_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_bytes_used    (m_bytes_used),
        .m_status        (m_status)
    );

    always #1 aclk = ~aclk;

    function automatic void drop_sequence();
        seq_len  = 2'd0;
        seq_seen = 2'd0;
        seq_bits = 10'd0;
    endfunction

    // Advance the mirrored state by one byte; return 1 when the byte yields a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                       output char_result_t r);
        logic [15:0] acc;
        logic [1:0]  seen;
        r.code_point = 16'h0000;
        r.bytes_used = 2'd0;
        r.status     = u2d_pkg::STATUS_OK;
        if (seq_len != 2'd2 && seq_len != 2'd3) begin
            drop_sequence();
            if (b[7] == 1'b0) begin
                r.code_point = {8'h00, b};
                r.bytes_used = 2'd1;
                return 1'b1;
            end
            if (b[7:5] == 3'b110) begin
                seq_len  = 2'd2;
                seq_bits = {5'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                seq_len  = 2'd3;
                seq_bits = {6'd0, b[3:0]};
            end else begin
                r.status = u2d_pkg::STATUS_ERROR;
                return 1'b1;
            end
            seq_seen = 2'd1;
            if (eob) begin
                drop_sequence();
                r.status = u2d_pkg::STATUS_PARTIAL;
                return 1'b1;
            end
            return 1'b0;
        end
        if (b[7:6] != 2'b10) begin
            drop_sequence();
            r.status = u2d_pkg::STATUS_ERROR;
            return 1'b1;
        end
        acc  = {seq_bits, b[5:0]};
        seen = seq_seen + 2'd1;
        if (seen >= seq_len) begin
            r.code_point = acc;
            r.bytes_used = seq_len;
            drop_sequence();
            return 1'b1;
        end
        if (eob) begin
            drop_sequence();
            r.status = u2d_pkg::STATUS_PARTIAL;
            return 1'b1;
        end
        seq_seen = seen;
        seq_bits = acc[9:0];
        return 1'b0;
    endfunction

    // Offer one item and hold it until accepted; returns with the handshake edge just past.
    task automatic offer_byte(input logic [7:0] b, input logic eob);
        s_valid         <= 1'b1;
        s_in_byte       <= b;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic maybe_idle();
        if (!no_idle && !hold_active && $urandom_range(99) < 5) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stimulus: directed rows, then random streams of mostly well-formed characters.
    initial begin
        char_result_t predicted;
        logic [8:0]   burst [$];
        logic [7:0]   b;
        int           kind;
        int           sent;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            maybe_idle();
            offer_byte(DIRECTED[i].in_byte, DIRECTED[i].eob);
            if (decode_byte(DIRECTED[i].in_byte, DIRECTED[i].eob, predicted) ||
                DIRECTED[i].typed) begin
                decoded_q.push_back(DIRECTED[i].typed ? DIRECTED[i].res : predicted);
            end
        end

        sent = 0;
        while (sent < NUM_RANDOM) begin
            kind = $urandom_range(99);
            burst.delete();
            if (kind < 30) begin
                burst.push_back({1'b0, 8'(($urandom_range(0, 127)))});
            end else if (kind < 55) begin
                burst.push_back({1'b0, 8'hc0 | 8'($urandom_range(0, 31))});
                burst.push_back({1'b0, 8'h80 | 8'($urandom_range(0, 63))});
            end else if (kind < 80) begin
                burst.push_back({1'b0, 8'he0 | 8'($urandom_range(0, 15))});
                burst.push_back({1'b0, 8'h80 | 8'($urandom_range(0, 63))});
                burst.push_back({1'b0, 8'h80 | 8'($urandom_range(0, 63))});
            end else if (kind < 88) begin
                burst.push_back({1'b0, 8'($urandom_range(0, 255))});
            end else if (kind < 94) begin
                // cut a sequence short; the next item lands on the pending state
                burst.push_back({1'b0, 8'he0 | 8'($urandom_range(0, 15))});
                if ($urandom_range(1)) begin
                    burst.push_back({1'b0, 8'h80 | 8'($urandom_range(0, 63))});
                end
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                burst.push_back({1'b0, 8'hc0 | 8'($urandom_range(0, 31))});
                burst.push_back({1'b0, b});
            end
            foreach (burst[j]) begin
                if ($urandom_range(99) < 8) burst[j][8] = 1'b1;
            end

            foreach (burst[j]) begin
                if (sent == 300) no_idle = 1'b1;
                if (sent == 450) no_idle = 1'b0;
                if (sent == 500) hold_req = 1'b1;
                if (sent == 650) begin
                    // pause until the block has drained
                    s_valid <= 1'b0;
                    while (decoded_q.size() != 0) @(posedge aclk);
                end
                maybe_idle();
                offer_byte(burst[j][7:0], burst[j][8]);
                if (decode_byte(burst[j][7:0], burst[j][8], predicted)) begin
                    decoded_q.push_back(predicted);
                end
                sent++;
            end
        end

        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("utf8_to_ucs2_decoder test passed");
        end else begin
            $display("utf8_to_ucs2_decoder test failed");
        end
        $finish;
    end

    // Result side: random stalls, a quiet stretch, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_ready    <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end
            m_ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        char_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected item: code_point=%h bytes_used=%0d status=%0d",
                         $time, m_code_point, m_bytes_used, m_status);
                mismatch_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_code_point !== want.code_point || m_bytes_used !== want.bytes_used ||
                    m_status !== want.status) begin
                    $display({"%0t: mismatch: expected cp=%h used=%0d st=%0d,",
                              " got cp=%h used=%0d st=%0d"},
                             $time, want.code_point, want.bytes_used, want.status,
                             m_code_point, m_bytes_used, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("utf8_to_ucs2_decoder test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/u2d_pkg.sv
hw/rtl/u2d_front.sv
hw/rtl/u2d_queue.sv
hw/rtl/u2d_back.sv
hw/rtl/utf8_to_ucs2_decoder.sv
bench/utf8_to_ucs2_decoder_tb.sv
